// File: design/hsl2rgb_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB package
// Fixed-point widths, pixel word types and the hue ramp used by the front stage.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

  localparam int FracBits = 16;
  localparam int HueW     = FracBits;
  localparam int LevelW   = FracBits + 1;
  localparam int ChanW    = 8;
  localparam int NumChan  = 3;

  localparam int UW   = FracBits + 3;       // hue times six, below 6*S
  localparam int WW   = FracBits + 1;       // ramp weight, 0..S
  localparam int MW   = 2 * FracBits;       // sat*min(l,1-l), up to S*S/2
  localparam int DW   = 2 * FracBits + 1;   // q-p and p, up to S*S
  localparam int VW   = 3 * FracBits + 1;   // channel value, up to S^3
  localparam int SclW = 3 * FracBits + 9;   // 255*value plus half

  localparam logic [LevelW-1:0] OneL  = LevelW'(1) << FracBits;
  localparam logic [LevelW-1:0] HalfL = LevelW'(1) << (FracBits - 1);

  localparam logic [UW-1:0] OneU   = UW'(1) << FracBits;
  localparam logic [UW-1:0] TwoU   = UW'(2) << FracBits;
  localparam logic [UW-1:0] ThreeU = UW'(3) << FracBits;
  localparam logic [UW-1:0] FourU  = UW'(4) << FracBits;
  localparam logic [UW-1:0] SixU   = UW'(6) << FracBits;

  localparam logic [SclW-1:0] RoundHalf = SclW'(1) << (3 * FracBits - 1);

  localparam int ChanRed   = 0;
  localparam int ChanGreen = 1;
  localparam int ChanBlue  = 2;

  typedef struct packed {
    logic [HueW-1:0]   hue;
    logic [LevelW-1:0] saturation;
    logic [LevelW-1:0] lightness;
  } hsl_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef logic [NumChan-1:0][WW-1:0] weight_t;

  function automatic logic [WW-1:0] hue_ramp(logic [UW-1:0] u);
    logic [WW-1:0] w;
    if (u < OneU) begin
      w = WW'(u);
    end else if (u < ThreeU) begin
      w = WW'(OneU);
    end else if (u < FourU) begin
      w = WW'(FourU - u);
    end else begin
      w = '0;
    end
    return w;
  endfunction

  function automatic logic [UW-1:0] hue_wrap(logic [UW-1:0] u, logic [UW-1:0] offs);
    logic [UW:0] sum;
    sum = {1'b0, u} + {1'b0, offs};
    if (sum >= {1'b0, SixU}) begin
      sum = sum - {1'b0, SixU};
    end
    return sum[UW-1:0];
  endfunction

endpackage

// File: design/hsl2rgb_front.sv
// ----------------------------------------------------------------------------
// HSL to RGB front stages
// Clamps saturation and lightness, builds the three hue ramp weights, then
// multiplies saturation by the distance of lightness from the nearer end.
// ----------------------------------------------------------------------------
module hsl2rgb_front import hsl2rgb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  hsl_t              data_i,
  output logic              valid_o,
  output logic [LevelW-1:0] lit_o,
  output logic [MW-1:0]     m_o,
  output weight_t           w_o
);

  logic [LevelW-1:0]   sat_c, lit_c;
  logic [FracBits-1:0] mn_c;
  logic [UW-1:0]       u_c;
  weight_t             w_c;

  logic                v1_q, v2_q;
  logic [LevelW-1:0]   sat1_q, lit1_q, lit2_q;
  logic [FracBits-1:0] mn1_q;
  weight_t             w1_q, w2_q;
  logic [MW-1:0]       m2_q;
  logic [MW:0]         m_full;

  always_comb begin
    sat_c = (data_i.saturation > OneL) ? OneL : data_i.saturation;
    lit_c = (data_i.lightness > OneL) ? OneL : data_i.lightness;
    mn_c  = (lit_c < HalfL) ? FracBits'(lit_c) : FracBits'(OneL - lit_c);
    u_c   = UW'({data_i.hue, 2'b00}) + UW'({data_i.hue, 1'b0});
    w_c[ChanRed]   = hue_ramp(hue_wrap(u_c, TwoU));
    w_c[ChanGreen] = hue_ramp(u_c);
    w_c[ChanBlue]  = hue_ramp(hue_wrap(u_c, FourU));
  end

  assign m_full = sat1_q * mn1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat1_q <= sat_c;
      lit1_q <= lit_c;
      mn1_q  <= mn_c;
      w1_q   <= w_c;
      lit2_q <= lit1_q;
      w2_q   <= w1_q;
      m2_q   <= m_full[MW-1:0];
    end
  end

  assign valid_o = v2_q;
  assign lit_o   = lit2_q;
  assign m_o     = m2_q;
  assign w_o     = w2_q;

endmodule

// File: design/hsl2rgb_mix.sv
// ----------------------------------------------------------------------------
// HSL to RGB mix stages
// Forms p and q-p, weights q-p by each channel's ramp and adds p back in.
// ----------------------------------------------------------------------------
module hsl2rgb_mix import hsl2rgb_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [LevelW-1:0]             lit_i,
  input  logic [MW-1:0]                 m_i,
  input  weight_t                       w_i,
  output logic                          valid_o,
  output logic [NumChan-1:0][VW-1:0]    val_o
);

  logic [DW-1:0]                 p_c, d_c;
  logic [NumChan-1:0][VW:0]      prod_c;
  logic                          v3_q, v4_q;
  logic [DW-1:0]                 p3_q;
  logic [NumChan-1:0][VW-1:0]    prod3_q, val4_q;

  always_comb begin
    p_c = {lit_i, {FracBits{1'b0}}} - {1'b0, m_i};
    d_c = {m_i, 1'b0};
    for (int c = 0; c < NumChan; c++) begin
      prod_c[c] = d_c * w_i[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p3_q <= p_c;
      for (int c = 0; c < NumChan; c++) begin
        prod3_q[c] <= prod_c[c][VW-1:0];
        val4_q[c]  <= {p3_q, {FracBits{1'b0}}} + prod3_q[c];
      end
    end
  end

  assign valid_o = v4_q;
  assign val_o   = val4_q;

endmodule

// File: design/hsl2rgb_out.sv
// ----------------------------------------------------------------------------
// HSL to RGB output buffer
// Scales each channel by 255 with rounding and saturation, and holds results
// in a two-word buffer so that upstream stall comes from a register.
// ----------------------------------------------------------------------------
module hsl2rgb_out import hsl2rgb_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [NumChan-1:0][VW-1:0] val_i,
  output logic                       en_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rgb_t                       out_data_o
);

  logic [NumChan-1:0][SclW-1:0]  scl_c;
  logic [NumChan-1:0][ChanW-1:0] chan_c;
  rgb_t                          word_c;

  rgb_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      scl_c[c] = {val_i[c], 8'b0} - SclW'(val_i[c]) + RoundHalf;
      if (scl_c[c][SclW-1]) begin
        chan_c[c] = '1;
      end else begin
        chan_c[c] = scl_c[c][SclW-2:3*FracBits];
      end
    end
    word_c.red   = chan_c[ChanRed];
    word_c.green = chan_c[ChanGreen];
    word_c.blue  = chan_c[ChanBlue];
  end

  assign en_o        = (cnt_q != 2'd2);
  assign push        = valid_i && en_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= word_c;
    end
  end

endmodule

// File: design/hsl_to_rgb_converter.sv
// Throughput: one pixel per cycle; four register stages plus a two-word output
// buffer, with the whole pipeline held only while that buffer is full.
// Reset: asynchronous, active low; clears valid bits and buffer pointers,
// and the block accepts words as soon as reset is released.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Pixel pipeline from 16-bit hue and 17-bit saturation and lightness to 8-bit RGB.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  hsl_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rgb_t out_data_o
);

  logic                       en;
  logic                       fr_valid, mx_valid;
  logic [LevelW-1:0]          fr_lit;
  logic [MW-1:0]              fr_m;
  weight_t                    fr_w;
  logic [NumChan-1:0][VW-1:0] mx_val;

  assign in_stall_o = !en;

  hsl2rgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .lit_o   (fr_lit),
    .m_o     (fr_m),
    .w_o     (fr_w)
  );

  hsl2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .lit_i   (fr_lit),
    .m_i     (fr_m),
    .w_i     (fr_w),
    .valid_o (mx_valid),
    .val_o   (mx_val)
  );

  hsl2rgb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (mx_valid),
    .val_i       (mx_val),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_stall_needs_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output buffer");

  a_stall_rise_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall raised without a held output word");

  a_stall_fall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> $past(!out_stall_i))
    else $error("input stall released without an output word taken");
`endif

endmodule

// File: sim/tb_hsl_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives pixels through the valid/stall handshake with random idle and stall
// bursts, predicts each RGB word with exact wide arithmetic and checks every
// output word in order against the prediction.
// ----------------------------------------------------------------------------
module tb_hsl_to_rgb_converter import hsl2rgb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QuietLimit = 2000;
  localparam int          DrainCycles = 12;
  localparam logic [127:0] Scale = 128'd1 << FracBits;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  hsl_t in_data;
  logic out_valid_o;
  logic out_stall;
  rgb_t out_data_o;

  rgb_t pending_rgb[$];
  int   mismatches = 0;
  int   quiet_cycles = 0;
  bit   sender_idles;
  bit   receiver_stalls;

  hsl_to_rgb_converter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [ChanW-1:0] ramp_level(input logic [127:0] u, p2, q2);
    logic [127:0] w;
    logic [127:0] scaled;
    if (u < Scale) begin
      w = u;
    end else if (u < 3 * Scale) begin
      w = Scale;
    end else if (u < 4 * Scale) begin
      w = 4 * Scale - u;
    end else begin
      w = '0;
    end
    scaled = ((p2 * Scale + (q2 - p2) * w) * 255 + (128'd1 << (3 * FracBits - 1)))
             >> (3 * FracBits);
    return (scaled > 255) ? 8'hFF : scaled[ChanW-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb_value(input hsl_t px);
    logic [127:0] sat;
    logic [127:0] lit;
    logic [127:0] q2;
    logic [127:0] p2;
    logic [127:0] u;
    rgb_t         rgb;
    sat = px.saturation;
    lit = px.lightness;
    if (sat > Scale) sat = Scale;
    if (lit > Scale) lit = Scale;
    if (2 * lit < Scale) begin
      q2 = lit * (Scale + sat);
    end else begin
      q2 = (lit + sat) * Scale - lit * sat;
    end
    p2 = 2 * lit * Scale - q2;
    u = 6 * px.hue;
    rgb.red   = ramp_level((u + 2 * Scale) % (6 * Scale), p2, q2);
    rgb.green = ramp_level(u, p2, q2);
    rgb.blue  = ramp_level((u + 4 * Scale) % (6 * Scale), p2, q2);
    return rgb;
  endfunction

  function automatic hsl_t pixel(input int h, input int s, input int l);
    hsl_t px;
    px.hue        = HueW'(h);
    px.saturation = LevelW'(s);
    px.lightness  = LevelW'(l);
    return px;
  endfunction

  function automatic logic [LevelW-1:0] random_level();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return OneL;
      2:       return HalfL;
      3:       return HalfL - 1;
      4:       return LevelW'($urandom_range(OneL + 1, (1 << LevelW) - 1));
      default: return LevelW'($urandom_range(0, OneL));
    endcase
  endfunction

  function automatic hsl_t random_pixel();
    hsl_t px;
    px.hue        = HueW'($urandom);
    px.saturation = random_level();
    px.lightness  = random_level();
    return px;
  endfunction

  task automatic send_pixel(input hsl_t px);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_rgb.push_back(hsl_to_rgb_value(px));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_pixel(pixel(0, 0, 0));
    send_pixel(pixel(0, 0, OneL));
    send_pixel(pixel(16'hFFFF, OneL, OneL));
    send_pixel(pixel(16'hFFFF, 17'h1FFFF, 17'h1FFFF));
    send_pixel(pixel(16'h5555, 17'h10001, HalfL));
    send_pixel(pixel(16'hAAAA, OneL, 17'h18000));
    send_pixel(pixel(0, 17'h0FFFF, 17'h0FFFF));
  endtask

  task automatic test_grey();
    send_pixel(pixel(16'h1234, 0, HalfL));
    send_pixel(pixel(16'hFEDC, 0, 1));
    send_pixel(pixel(16'h8000, 0, 17'h0ABCD));
    send_pixel(pixel(16'h4321, 0, 17'h1FFFF));
  endtask

  task automatic test_hue_ramp();
    send_pixel(pixel(0, OneL, HalfL));
    send_pixel(pixel(21845, OneL, HalfL));
    send_pixel(pixel(43691, OneL, HalfL));
    send_pixel(pixel(10922, OneL, HalfL));
    send_pixel(pixel(10923, OneL, HalfL));
    send_pixel(pixel(32768, OneL, HalfL));
    send_pixel(pixel(43690, OneL, HalfL - 1));
    send_pixel(pixel(54613, 17'h08000, HalfL - 1));
    send_pixel(pixel(5461, 17'h0C000, 17'h04000));
    send_pixel(pixel(60000, 17'h0C000, 17'h0C000));
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(random_pixel());
    end
  endtask

  task automatic test_drain_pause();
    for (int burst = 0; burst < 5; burst++) begin
      for (int i = 0; i < 20; i++) begin
        send_pixel(random_pixel());
      end
      wait_drained();
      @(posedge clk_i);
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni === 1'b1 && out_valid_o && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual %h/%h/%h", $time,
                 out_data_o.red, out_data_o.green, out_data_o.blue);
      end else begin
        want = pending_rgb.pop_front();
        if (want.red !== out_data_o.red || want.green !== out_data_o.green ||
            want.blue !== out_data_o.blue) begin
          mismatches++;
          $display("%0t: rgb expected %h/%h/%h, actual %h/%h/%h", $time,
                   want.red, want.green, want.blue,
                   out_data_o.red, out_data_o.green, out_data_o.blue);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("hsl_to_rgb_converter: mismatch");
    $finish;
  end

  initial begin
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_extremes();
    test_grey();
    test_hue_ramp();
    test_random_stream(250);
    test_drain_pause();
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    test_random_stream(80);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("hsl_to_rgb_converter: match");
    end else begin
      $display("hsl_to_rgb_converter: mismatch");
    end
    $finish;
  end

endmodule
